FILE: sv/polygon_scanline_span_core_macros.svh
// Assertion macros shared by the scanline span core.
`ifndef POLYGON_SCANLINE_SPAN_CORE_MACROS_SVH
`define POLYGON_SCANLINE_SPAN_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("span core check failed");
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("span core check failed");
`define PSS_ASSERT_NEVER(lbl, cond) `PSS_ASSERT_IMPL(lbl, 1'b1, !(cond))
`else
`define PSS_ASSERT_IMPL(lbl, ante, cons)
`define PSS_ASSERT_NEXT(lbl, ante, cons)
`define PSS_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: sv/pss_pkg.sv
// Shared types and constants of the scanline span core.
`default_nettype none
package pss_pkg;

  localparam int ROW_W   = 12;
  localparam int COORD_W = 16;
  localparam int DY_W    = COORD_W + 1;
  localparam int PIX_W   = 11;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_LIMIT    = 12'd2048;
  localparam logic [CFG_W-1:0] WIDTH_RESET    = 12'd480;
  localparam logic [CFG_W-1:0] HEIGHT_RESET   = 12'd272;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] row;
    logic                    last;
    logic                    crosses;
  } edge_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_ABS,
    ST_DIV,
    ST_FIX,
    ST_ACC,
    ST_EMIT
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/polygon_scanline_span_core.sv
// Back stage: an edge that crosses its row passes through sum, absolute value, divide
// (one quotient bit per cycle over the numerator width), fix and accumulate; an edge
// that does not cross goes straight to accumulate, and a last edge then loads its span.
// Throughput is set by the bit-serial divider; a four-entry queue lets the front keep
// accepting edges meanwhile. Reset is synchronous and active low; it empties the
// pipeline, clears the accumulators and restores width 480 and height 272.
`default_nettype none
`include "polygon_scanline_span_core_macros.svh"
module polygon_scanline_span_core
  import pss_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 4,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // row, edge_ax, edge_ay, edge_bx, edge_by, zero padding
  input  wire logic [79:0]          in_tdata,
  input  wire logic                 in_tlast,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // span_row, x_start, x_end, zero padding
  output logic [39:0]               out_tdata,
  // has_span
  output logic                      out_tuser,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int RQ_W  = ROW_W + COORD_FRAC_BITS;
  localparam int DR_W  = ((RQ_W > COORD_W) ? RQ_W : COORD_W) + 1;
  localparam int PA_W  = COORD_W + DY_W;
  localparam int PB_W  = DY_W + DR_W;
  localparam int CTL_W = $bits(edge_ctl_t);
  localparam int ENT_W = PA_W + PB_W + DY_W + CTL_W;

  frame_cfg_t cfg_r;
  q_status_t  q_status;
  logic       q_push, q_pop;
  logic signed [PA_W-1:0] f_pa, b_pa;
  logic signed [PB_W-1:0] f_pb, b_pb;
  logic signed [DY_W-1:0] f_dy, b_dy;
  edge_ctl_t  f_ctl, b_ctl;
  logic [ENT_W-1:0] q_wdata, q_rdata;
  logic [PIX_W-1:0] span_row, x_start, x_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= WIDTH_RESET;
      cfg_r.height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  cfg_r.width  <= cfg_wdata;
        REG_FRAME_HEIGHT: cfg_r.height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  pss_front #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .RQ_W(RQ_W),
    .DR_W(DR_W),
    .PA_W(PA_W),
    .PB_W(PB_W)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .row(in_tdata[11:0]),
    .edge_ax(in_tdata[27:12]),
    .edge_ay(in_tdata[43:28]),
    .edge_bx(in_tdata[59:44]),
    .edge_by(in_tdata[75:60]),
    .last_edge(in_tlast),
    .q_status(q_status),
    .q_push(q_push),
    .pa(f_pa),
    .pb(f_pb),
    .dy(f_dy),
    .ctl(f_ctl)
  );

  assign q_wdata = {f_pa, f_pb, f_dy, f_ctl};

  pss_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .wdata(q_wdata),
    .pop(q_pop),
    .rdata(q_rdata),
    .status(q_status)
  );

  assign {b_pa, b_pb, b_dy, b_ctl} = q_rdata;

  pss_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .PA_W(PA_W),
    .PB_W(PB_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg_r),
    .q_status(q_status),
    .q_pop(q_pop),
    .pa(b_pa),
    .pb(b_pb),
    .dy(b_dy),
    .ctl(b_ctl),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .span_row(span_row),
    .x_start(x_start),
    .x_end(x_end),
    .has_span(out_tuser)
  );

  assign out_tdata = {7'd0, x_end, x_start, span_row};

  `PSS_ASSERT_NEVER(a_no_overflow, q_push && q_status.full)
  `PSS_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_status.empty)
  `PSS_ASSERT_IMPL(a_span_order, out_tvalid && out_tuser, x_start <= x_end)
  `PSS_ASSERT_IMPL(a_empty_zero, out_tvalid && !out_tuser, out_tdata == '0)

endmodule
`default_nettype wire

FILE: sv/pss_front.sv
// Front stage: registers an edge, tests the crossing and forms both products.
`default_nettype none
module pss_front
  import pss_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 4,
  parameter int RQ_W = ROW_W + COORD_FRAC_BITS,
  parameter int DR_W = ((RQ_W > COORD_W) ? RQ_W : COORD_W) + 1,
  parameter int PA_W = COORD_W + DY_W,
  parameter int PB_W = DY_W + DR_W
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [ROW_W-1:0]    row,
  input  wire logic signed [COORD_W-1:0]  edge_ax,
  input  wire logic signed [COORD_W-1:0]  edge_ay,
  input  wire logic signed [COORD_W-1:0]  edge_bx,
  input  wire logic signed [COORD_W-1:0]  edge_by,
  input  wire logic                       last_edge,
  input  wire q_status_t                  q_status,
  output logic                            q_push,
  output logic signed [PA_W-1:0]          pa,
  output logic signed [PB_W-1:0]          pb,
  output logic signed [DY_W-1:0]          dy,
  output edge_ctl_t                       ctl
);

  logic signed [RQ_W-1:0]    rq;
  logic                      crosses;
  logic                      a_valid_r, a_valid_nxt;
  logic signed [COORD_W-1:0] ax_r;
  logic signed [DY_W-1:0]    dy_r;
  logic signed [DY_W-1:0]    dx_r;
  logic signed [DR_W-1:0]    dr_r;
  edge_ctl_t                 ctl_r;
  logic                      accept;

  assign rq      = RQ_W'(row) <<< COORD_FRAC_BITS;
  assign crosses = ((edge_ay <= rq) && (edge_by > rq)) ||
                   ((edge_by <= rq) && (edge_ay > rq));

  assign in_ready = !a_valid_r || !q_status.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = a_valid_r && !q_status.full;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ax_r      <= edge_ax;
      dy_r      <= DY_W'(edge_by) - DY_W'(edge_ay);
      dx_r      <= DY_W'(edge_bx) - DY_W'(edge_ax);
      dr_r      <= DR_W'(rq) - DR_W'(edge_ay);
      ctl_r.row     <= row;
      ctl_r.last    <= last_edge;
      ctl_r.crosses <= crosses;
    end
  end

  assign pa  = PA_W'(ax_r) * PA_W'(dy_r);
  assign pb  = PB_W'(dx_r) * PB_W'(dr_r);
  assign dy  = dy_r;
  assign ctl = ctl_r;

endmodule
`default_nettype wire

FILE: sv/pss_queue.sv
// Small first-in first-out queue between the front and back stages.
`default_nettype none
module pss_queue
  import pss_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output q_status_t             status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

FILE: sv/pss_back.sv
// Back stage: bit-serial divider, min/max accumulation and span output.
`default_nettype none
module pss_back
  import pss_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 4,
  parameter int PA_W = 33,
  parameter int PB_W = 34
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire frame_cfg_t           cfg,
  input  wire q_status_t            q_status,
  output logic                      q_pop,
  input  wire logic signed [PA_W-1:0] pa,
  input  wire logic signed [PB_W-1:0] pb,
  input  wire logic signed [DY_W-1:0] dy,
  input  wire edge_ctl_t            ctl,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          span_row,
  output logic [PIX_W-1:0]          x_start,
  output logic [PIX_W-1:0]          x_end,
  output logic                      has_span
);

  localparam int NUM_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int DVS_W = COORD_W;
  localparam int XW    = COORD_W + 1;

  back_state_t state_r, state_nxt;

  logic signed [PA_W-1:0]    pa_r;
  logic signed [PB_W-1:0]    pb_r;
  logic signed [DY_W-1:0]    dy_r;
  edge_ctl_t                 ctl_r;
  logic signed [NUM_W-1:0]   num_r;
  logic [NUM_W-1:0]          dvd_r;
  logic [DVS_W-1:0]          dvs_r;
  logic [DVS_W-1:0]          rem_r;
  logic                      neg_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [COORD_W-1:0] x_r;
  logic signed [COORD_W-1:0] min_r, max_r;
  logic                      any_r;
  logic                      out_valid_r;
  logic [PIX_W-1:0]          span_row_r, x_start_r, x_end_r;
  logic                      has_span_r;

  logic                      out_load;
  logic                      out_free;
  logic [DVS_W:0]            rem_sh;
  logic                      qbit;
  logic [DVS_W:0]            rem_sub;
  logic [NUM_W-1:0]          num_abs;
  logic [DY_W-1:0]           dy_abs;
  logic [XW-1:0]             q_mag;
  logic [XW-1:0]             q_neg;

  logic [CFG_W-1:0]          w_eff, h_eff;
  logic signed [CFG_W:0]     wm1;
  logic signed [XW-1:0]      mneg;
  logic signed [XW-1:0]      xs_pix, xe_pix, xe_clip;
  logic                      row_ok, span_ok;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          state_nxt = ctl.crosses ? ST_SUM : ST_ACC;
        end
      end
      ST_SUM:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ctl_r.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: q_pop    = !q_status.empty;
      ST_EMIT: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  assign rem_sh  = {rem_r, dvd_r[NUM_W-1]};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign num_abs = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign dy_abs  = dy_r[DY_W-1] ? DY_W'(-dy_r) : DY_W'(dy_r);
  assign q_mag   = dvd_r[XW-1:0];
  assign q_neg   = XW'(-q_mag);

  assign w_eff   = (cfg.width > FRAME_LIMIT) ? FRAME_LIMIT : cfg.width;
  assign h_eff   = (cfg.height > FRAME_LIMIT) ? FRAME_LIMIT : cfg.height;
  assign wm1     = $signed({1'b0, w_eff}) - 13'sd1;
  assign mneg    = -XW'(max_r);
  assign xs_pix  = min_r[COORD_W-1] ? '0 : (XW'(min_r) >>> COORD_FRAC_BITS);
  assign xe_pix  = max_r[COORD_W-1] ? -(mneg >>> COORD_FRAC_BITS)
                                    : (XW'(max_r) >>> COORD_FRAC_BITS);
  assign xe_clip = (xe_pix > XW'(wm1)) ? XW'(wm1) : xe_pix;
  assign row_ok  = !ctl_r.row[ROW_W-1] && (CFG_W'(ctl_r.row) < h_eff);
  assign span_ok = any_r && row_ok && !(xs_pix > xe_clip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      any_r       <= 1'b0;
      min_r       <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_ACC && ctl_r.crosses) begin
        if (!any_r || x_r < min_r) begin
          min_r <= x_r;
        end
        if (!any_r || x_r > max_r) begin
          max_r <= x_r;
        end
        any_r <= 1'b1;
      end
      if (out_load) begin
        any_r <= 1'b0;
        min_r <= '0;
        max_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        pa_r  <= pa;
        pb_r  <= pb;
        dy_r  <= dy;
        ctl_r <= ctl;
      end
      ST_SUM: num_r <= NUM_W'(pa_r) + NUM_W'(pb_r);
      ST_ABS: begin
        dvd_r <= num_abs;
        dvs_r <= dy_abs[DVS_W-1:0];
        rem_r <= '0;
        neg_r <= num_r[NUM_W-1] ^ dy_r[DY_W-1];
        cnt_r <= CNT_W'(NUM_W - 1);
      end
      ST_DIV: begin
        rem_r <= qbit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        dvd_r <= {dvd_r[NUM_W-2:0], qbit};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_FIX: x_r <= neg_r ? q_neg[COORD_W-1:0] : q_mag[COORD_W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      has_span_r <= span_ok;
      span_row_r <= span_ok ? ctl_r.row[PIX_W-1:0] : '0;
      x_start_r  <= span_ok ? xs_pix[PIX_W-1:0] : '0;
      x_end_r    <= span_ok ? xe_clip[PIX_W-1:0] : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign span_row  = span_row_r;
  assign x_start   = x_start_r;
  assign x_end     = x_end_r;
  assign has_span  = has_span_r;

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the scanline span core with a built-in span predictor.
`timescale 1ns / 1ps
module tb_top;
  import pss_pkg::*;

  localparam int FRAC        = 4;
  localparam int SETTLE      = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int N_PHASES    = 7;

  typedef struct packed {
    logic signed [ROW_W-1:0]   row;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic                      last;
  } edge_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] row;
    logic [PIX_W-1:0] xs;
    logic [PIX_W-1:0] xe;
    logic             has;
  } span_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  wire                  in_tready;
  // row, edge_ax, edge_ay, edge_bx, edge_by, zero padding
  logic [79:0]          in_tdata = '0;
  logic                 in_tlast = 1'b0;
  wire                  out_tvalid;
  logic                 out_tready = 1'b0;
  // span_row, x_start, x_end, zero padding
  wire  [39:0]          out_tdata;
  // has_span
  wire                  out_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  polygon_scanline_span_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  edge_item_t       edge_q[$];
  span_t            span_q[$];
  edge_item_t       held;
  span_t            got;
  span_t            want;
  logic [CFG_W-1:0] frame_w = WIDTH_RESET;
  logic [CFG_W-1:0] frame_h = HEIGHT_RESET;
  int               lo_x;
  int               hi_x;
  bit               seen;
  int               send_idle;
  int               recv_idle;
  int               n_queued;
  int               n_edges;
  int               n_spans;
  int               n_filled;
  int               n_errors;
  int               stall_cnt;

  int ph_w[N_PHASES] = '{480, 1, 2048, 4095, 0, 640, 37};
  int ph_h[N_PHASES] = '{272, 1, 2048, 4095, 0, 480, 2000};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Span predictor: accumulates edge crossings and emits the clipped span on the last edge.
  task automatic take_edge(edge_item_t e);
    longint rq;
    longint ax;
    longint ay;
    longint bx;
    longint by;
    longint dy;
    longint num;
    int     x;
    int     xs;
    int     xe;
    int     w;
    int     h;
    bit     ok;
    span_t  s;
    rq = longint'(e.row) * (1 << FRAC);
    ax = longint'(e.ax);
    ay = longint'(e.ay);
    bx = longint'(e.bx);
    by = longint'(e.by);
    if ((ay <= rq && by > rq) || (by <= rq && ay > rq)) begin
      dy  = by - ay;
      num = ax * dy + (bx - ax) * (rq - ay);
      x   = int'(num / dy);
      if (!seen || x < lo_x) lo_x = x;
      if (!seen || x > hi_x) hi_x = x;
      seen = 1'b1;
    end
    if (e.last) begin
      w  = int'((frame_w > FRAME_LIMIT) ? FRAME_LIMIT : frame_w);
      h  = int'((frame_h > FRAME_LIMIT) ? FRAME_LIMIT : frame_h);
      xs = lo_x / (1 << FRAC);
      xe = hi_x / (1 << FRAC);
      ok = seen && e.row >= 0 && int'(e.row) < h;
      if (xs < 0) xs = 0;
      if (xe > w - 1) xe = w - 1;
      if (xs > xe) ok = 1'b0;
      s = '0;
      if (ok) begin
        s.row = e.row[PIX_W-1:0];
        s.xs  = xs[PIX_W-1:0];
        s.xe  = xe[PIX_W-1:0];
        s.has = 1'b1;
      end
      span_q.push_back(s);
      lo_x = 0;
      hi_x = 0;
      seen = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        take_edge(held);
        n_edges++;
      end
      if (!in_tvalid || in_tready) begin
        if (edge_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          held = edge_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, held.by, held.bx, held.ay, held.ax, held.row};
          in_tlast  <= held.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[10:0], out_tdata[21:11], out_tdata[32:22], out_tuser};
        if (span_q.size() == 0) begin
          $display("%0t: unexpected span row %0d x %0d..%0d has_span %0b",
                   $time, got.row, got.xs, got.xe, got.has);
          n_errors++;
        end else begin
          want = span_q.pop_front();
          n_spans++;
          if (want.has) n_filled++;
          if (got !== want) begin
            $display("%0t: span mismatch expected row %0d x %0d..%0d has_span %0b",
                     $time, want.row, want.xs, want.xe, want.has);
            $display("%0t:                 actual row %0d x %0d..%0d has_span %0b",
                     $time, got.row, got.xs, got.xe, got.has);
            n_errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cnt <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a beat.", stall_cnt);
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand16();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v;
  endfunction

  function automatic int rand_x(int ew);
    if ($urandom_range(0, 9) < 7) return sat16(int'($urandom_range(0, ew * 16 + 128)) - 64);
    return rand16();
  endfunction

  function automatic int near_row(int eh);
    int r;
    r = int'($urandom_range(0, eh + 3)) - 3;
    return (r > 2047) ? 2047 : r;
  endfunction

  task automatic add_edge(int row, int ax, int ay, int bx, int by, bit last);
    edge_item_t e;
    e.row  = row[ROW_W-1:0];
    e.ax   = ax[COORD_W-1:0];
    e.ay   = ay[COORD_W-1:0];
    e.bx   = bx[COORD_W-1:0];
    e.by   = by[COORD_W-1:0];
    e.last = last;
    edge_q.push_back(e);
    n_queued++;
  endtask

  task automatic add_directed();
    add_edge(10, 88, 0, 88, 320, 0);
    add_edge(10, 1600, 320, 1600, 0, 1);
    add_edge(5, 0, 80, 800, 80, 1);
    add_edge(0, -32768, -32768, 32767, 32767, 0);
    add_edge(0, 32767, 32767, 32767, -32768, 1);
    add_edge(-2048, -16, -32768, -16, 0, 1);
    add_edge(2047, 3200, 32767, 4800, 0, 1);
    add_edge(271, 160, 0, 160, 8000, 0);
    add_edge(271, 5000, 8000, 5200, 0, 1);
    add_edge(272, 160, 0, 160, 8000, 1);
    add_edge(3, 48, 0, 48, 100, 0);
    add_edge(50, 960, 0, 960, 1000, 1);
    add_edge(1, -100, 0, 50, 33, 1);
    add_edge(4, 0, 64, 500, 200, 0);
    add_edge(4, 640, 300, 640, 64, 0);
    add_edge(4, 3000, 0, 3000, 64, 1);
    add_edge(100, 500, 0, 900, 1000, 0);
    add_edge(100, 500, 2000, 900, 3000, 1);
  endtask

  task automatic add_polygon();
    int n;
    int k;
    int row;
    int rq;
    int a;
    int b;
    int t;
    int spread;
    int eh;
    int ew;
    eh = int'((frame_h > FRAME_LIMIT) ? FRAME_LIMIT : frame_h);
    ew = int'((frame_w > FRAME_LIMIT) ? FRAME_LIMIT : frame_w);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        add_edge($urandom, rand16(), rand16(), rand16(), rand16(),
                 $urandom_range(0, 1) == 1);
      return;
    end
    row = ($urandom_range(0, 6) == 0) ? int'($urandom_range(0, 4095)) - 2048 : near_row(eh);
    n = $urandom_range(1, 6);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) row = near_row(eh);
      rq = row * (1 << FRAC);
      if ($urandom_range(0, 3) != 0) begin
        spread = ($urandom_range(0, 3) == 0) ? 30000 : 800;
        a = sat16(rq - int'($urandom_range(0, spread)));
        b = sat16(rq + int'($urandom_range(1, spread)));
      end else begin
        a = rand16();
        b = rand16();
      end
      if ($urandom_range(0, 1)) begin
        t = a;
        a = b;
        b = t;
      end
      add_edge(row, rand_x(ew), a, rand_x(ew), b,
               k == n - 1 && $urandom_range(0, 19) != 0);
    end
  endtask

  task automatic wait_drained();
    while (edge_q.size() != 0 || in_tvalid || span_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_frame(int w, int h);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    frame_w = w[CFG_W-1:0];
    frame_h = h[CFG_W-1:0];
    @(negedge clk);
  endtask

  initial begin
    int ph;
    int goal;
    send_idle = 37;
    recv_idle = 52;
    goal      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 3) begin
        send_idle = 52;
        recv_idle = 37;
      end
      if (ph == 5) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_frame(ph_w[ph], ph_h[ph]);
      if (ph == 0) add_directed();
      goal += (ph_w[ph] == 0) ? 60 : 130;
      while (n_queued < goal) add_polygon();
    end
    wait_drained();
    $display("Run covered %0d edges and %0d spans, %0d of them filled,",
             n_edges, n_spans, n_filled);
    $display("over %0d frame settings from zero up to oversized registers.", N_PHASES);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/pss_pkg.sv
sv/pss_front.sv
sv/pss_queue.sv
sv/pss_back.sv
sv/polygon_scanline_span_core.sv
dv/tb_top.sv
